// ----- rtl/jmsw_pkg.sv -----
package jmsw_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int FIELD_W = 24;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_BAD_SOI   = 3'd1;
  localparam logic [2:0] ST_NO_FF     = 3'd2;
  localparam logic [2:0] ST_SHORT_LEN = 3'd3;
  localparam logic [2:0] ST_EARLY_END = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOF1   = 8'hC1;
  localparam logic [7:0] MK_SOS    = 8'hDA;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FIELD_W-1:0] scan_offset;
    logic [FIELD_W-1:0] height_offset;
  } out_t;

endpackage

// ----- rtl/jpeg_marker_segment_walker_unit.sv -----
// Path: an accepted byte waits in the input register; a result it completes moves on to the result register.
// Throughput: one byte per cycle while results are taken; a held result stalls the
// walker, and the input register can take at most one more byte until it leaves.
// Reset (rst_n low, synchronous) empties both registers and rearms the walker to
// expect the first start-of-image byte at offset zero.
module jpeg_marker_segment_walker_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jmsw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jmsw_pkg::out_t out_data
);
  import jmsw_pkg::*;

  localparam logic [2:0] PH_SOI0   = 3'd0;
  localparam logic [2:0] PH_SOI1   = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_CODE   = 3'd3;
  localparam logic [2:0] PH_LEN_HI = 3'd4;
  localparam logic [2:0] PH_LEN_LO = 3'd5;
  localparam logic [2:0] PH_BODY   = 3'd6;
  localparam logic [2:0] PH_IGNORE = 3'd7;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic                   s1_valid_r;
  in_t                    s1_data_r;
  logic                   out_valid_r;
  out_t                   out_data_r;
  out_t                   out_data_nxt;

  logic [2:0]             phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]             marker_r, marker_nxt;
  logic [15:0]            seg_len_r, seg_len_nxt;
  logic [15:0]            skip_r, skip_nxt;
  logic [OFFSET_BITS-1:0] fho_r, fho_nxt;

  logic                   out_free;
  logic                   s1_go;
  logic                   has_res;
  logic [2:0]             res_status;
  logic [OFFSET_BITS-1:0] scan_pos;
  logic                   tail;
  logic                   standalone;
  logic [7:0]             b;
  logic [OFFSET_BITS+FIELD_W-1:0] scan_ext;
  logic [OFFSET_BITS+FIELD_W-1:0] fho_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = s1_data_r.data_byte;

  assign standalone = (b == MK_SOI) || (b == MK_TEM) || ((b >= MK_RST0) && (b <= MK_RST7));

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    marker_nxt  = marker_r;
    seg_len_nxt = seg_len_r;
    skip_nxt    = skip_r;
    fho_nxt     = fho_r;
    has_res     = 1'b0;
    res_status  = ST_FOUND;
    scan_pos    = '0;
    tail        = 1'b0;

    if (phase_r != PH_IGNORE) begin
      if (pos_r == POS_MAX) begin
        has_res    = 1'b1;
        res_status = ST_TOO_LONG;
      end else begin
        pos_nxt = pos_r + 1'b1;
        case (phase_r)
          PH_SOI0: begin
            if (b != MK_PREFIX) begin
              has_res    = 1'b1;
              res_status = ST_BAD_SOI;
            end else begin
              phase_nxt = PH_SOI1;
            end
          end
          PH_SOI1: begin
            if (b != MK_SOI) begin
              has_res    = 1'b1;
              res_status = ST_BAD_SOI;
            end else begin
              phase_nxt = PH_PREFIX;
            end
          end
          PH_PREFIX: begin
            if (b != MK_PREFIX) begin
              has_res    = 1'b1;
              res_status = ST_NO_FF;
            end else begin
              phase_nxt = PH_CODE;
            end
          end
          PH_CODE: begin
            marker_nxt = b;
            phase_nxt  = standalone ? PH_PREFIX : PH_LEN_HI;
          end
          PH_LEN_HI: begin
            seg_len_nxt = {b, 8'h00};
            phase_nxt   = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            seg_len_nxt = {seg_len_r[15:8], b};
            if (seg_len_nxt < 16'd2) begin
              has_res    = 1'b1;
              res_status = ST_SHORT_LEN;
            end else begin
              if ((marker_r == MK_SOF0) || (marker_r == MK_SOF1)) begin
                fho_nxt = pos_r + OFFSET_BITS'(2);
              end
              skip_nxt = seg_len_nxt - 16'd2;
              tail     = 1'b1;
            end
          end
          PH_BODY: begin
            skip_nxt = skip_r - 16'd1;
            tail     = 1'b1;
          end
          default: begin
          end
        endcase
        if (tail) begin
          if (skip_nxt != 16'd0) begin
            phase_nxt = PH_BODY;
          end else if (marker_r == MK_SOS) begin
            has_res    = 1'b1;
            res_status = ST_FOUND;
            scan_pos   = pos_r + 1'b1;
          end else begin
            phase_nxt = PH_PREFIX;
          end
        end
      end
      if (!has_res && s1_data_r.last_byte) begin
        has_res    = 1'b1;
        res_status = ST_EARLY_END;
      end
      if (has_res && !s1_data_r.last_byte) begin
        phase_nxt = PH_IGNORE;
      end
    end

    scan_ext = {{FIELD_W{1'b0}}, scan_pos};
    fho_ext  = {{FIELD_W{1'b0}}, fho_nxt};
    out_data_nxt.status        = res_status;
    out_data_nxt.scan_offset   = scan_ext[FIELD_W-1:0];
    out_data_nxt.height_offset = fho_ext[FIELD_W-1:0];

    if (s1_data_r.last_byte && (has_res || phase_r == PH_IGNORE)) begin
      phase_nxt   = PH_SOI0;
      pos_nxt     = '0;
      marker_nxt  = '0;
      seg_len_nxt = '0;
      skip_nxt    = '0;
      fho_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SOI0;
      pos_r       <= '0;
      marker_r    <= '0;
      seg_len_r   <= '0;
      skip_r      <= '0;
      fho_r       <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        marker_r  <= marker_nxt;
        seg_len_r <= seg_len_nxt;
        skip_r    <= skip_nxt;
        fho_r     <= fho_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_go && has_res) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/jmsw_checker.sv -----
module jmsw_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input jmsw_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input jmsw_pkg::out_t out_data
);
  import jmsw_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_TOO_LONG)
    else $error("status code out of range");

  a_fail_scan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_FOUND |-> out_data.scan_offset == '0)
    else $error("failure result carries a scan offset");

  a_found_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FOUND |-> out_data.scan_offset >= FIELD_W'(6))
    else $error("scan offset too small for a valid file");

endmodule

bind jpeg_marker_segment_walker_unit jmsw_checker u_jmsw_checker (.*);
